// ===== sv/evs_pkg.sv =====
// Shared constants, register codes and root-table functions for the volume swell block.
`timescale 1ns / 1ps
package evs_pkg;

  localparam int VOLUME_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_FRAC_BITS   = 24;

  localparam int TIME_BITS      = 16;
  localparam int INTERVAL_BITS  = 8;
  localparam int ELAPSED_BITS   = 17;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWELL_TIME      = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPDATE_INTERVAL = 1'b1;

  localparam logic [TIME_BITS-1:0]     SWELL_TIME_RESET      = 16'd4000;
  localparam logic [INTERVAL_BITS-1:0] UPDATE_INTERVAL_RESET = 8'd5;

  localparam int BASE_M1_BITS = 10;
  localparam logic [BASE_M1_BITS-1:0] BASE_M1 = 10'd999;
  localparam logic [63:0] CURVE_BASE = 64'd1000;

  localparam int Q_ONE_BITS = 26;
  localparam int E_BITS     = 36;
  localparam int ROOT_BITS  = 32;
  localparam int MUL_DIGIT  = 8;
  localparam int MUL_STEPS  = ROOT_BITS / MUL_DIGIT;
  localparam int PROD_BITS  = E_BITS + ROOT_BITS;
  localparam logic [E_BITS-1:0] E_ONE = E_BITS'(64'd1 << Q_ONE_BITS);

  // Floor square root of a 64-bit value, used only while elaborating the root table.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] w;
    logic [63:0] r;
    logic [63:0] b;
    w = v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > w) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 64'd0) begin
        if (w >= r + b) begin
          w = w - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // The k-th repeated square root of 1000 in Q.26.
  function automatic logic [ROOT_BITS-1:0] curve_root(input int k);
    logic [63:0] root;
    root = CURVE_BASE << Q_ONE_BITS;
    for (int i = 0; i < MAX_FRAC_BITS; i++) begin
      if (i < k) root = isqrt64(root << Q_ONE_BITS);
    end
    return root[ROOT_BITS-1:0];
  endfunction

endpackage

// ===== sv/exponential_volume_swell_unit.sv =====
// Top level of the exponential volume swell envelope with stream ports and configuration writes.
`timescale 1ns / 1ps
// The block takes one beat at a time: a start beat or a 1 ms tick, and returns one result
// beat for each. A start beat or a tick that needs no new curve point goes to the finish
// state, which loads its result into the output register once that register is free. A
// tick that reaches a sample point first runs the curve sequencer. A point whose curve
// position (the elapsed time, or for a falling swell the time left) is at or beyond the
// swell length takes the pot level as its result; any other runs the serial time fraction
// divide, one pass of the byte-serial multiplier per root for each set bit of that fraction,
// the pot scaling and the divide by 999 before the result is handed over. The next beat is
// taken once the previous result sits in the output register, even while the consumer has not yet taken it.
module exponential_volume_swell_unit #(
  parameter int VOLUME_BITS = evs_pkg::VOLUME_BITS_DEF,
  parameter int FRAC_BITS   = evs_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [evs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [evs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // inverted, pot_level
  input  logic [((VOLUME_BITS+8)/8)*8-1:0]    s_axis_tdata,
  // req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // volume, volume_changed, swell_active
  output logic [((VOLUME_BITS+9)/8)*8-1:0]    m_axis_tdata
);
  import evs_pkg::*;

  localparam int OUT_W = ((VOLUME_BITS + 9) / 8) * 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  logic [1:0]               state;
  logic [TIME_BITS-1:0]     swell_time_ms;
  logic [INTERVAL_BITS-1:0] update_interval_ms;
  logic                     active;
  logic                     falling;
  logic [ELAPSED_BITS-1:0]  elapsed_ms;
  logic [ELAPSED_BITS-1:0]  sample_ms;
  logic [VOLUME_BITS-1:0]   current_volume;
  logic [VOLUME_BITS-1:0]   held_pot;
  logic [VOLUME_BITS-1:0]   target_volume;
  logic [VOLUME_BITS-1:0]   vol_before;

  logic                     in_inverted;
  logic [VOLUME_BITS-1:0]   in_pot;
  logic [ELAPSED_BITS-1:0]  elapsed_inc;
  logic                     need_sample;
  logic                     accept;
  logic                     curve_go;
  logic                     curve_done;
  logic [VOLUME_BITS-1:0]   curve_y;
  logic                     end_hit;
  logic [VOLUME_BITS-1:0]   cur_fin;
  logic                     act_fin;
  logic                     out_free;

  assign in_inverted   = s_axis_tdata[0];
  assign in_pot        = s_axis_tdata[VOLUME_BITS:1];
  assign s_axis_tready = state == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign elapsed_inc   = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
  assign need_sample   = (elapsed_inc - sample_ms) >= ELAPSED_BITS'(update_interval_ms);
  assign curve_go      = accept && !s_axis_tuser && active && need_sample;

  // A swell ends past its length or once the volume sits on the target.
  assign end_hit  = (sample_ms > ELAPSED_BITS'(swell_time_ms)) || (current_volume == target_volume);
  assign cur_fin  = (active && end_hit) ? target_volume : current_volume;
  assign act_fin  = active && !end_hit;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  evs_curve #(
    .VOLUME_BITS (VOLUME_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_curve (
    .clk     (clk),
    .rst     (rst),
    .start   (curve_go),
    .x       (sample_ms),
    .t       (swell_time_ms),
    .falling (falling),
    .pot     (held_pot),
    .done    (curve_done),
    .y       (curve_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      swell_time_ms      <= SWELL_TIME_RESET;
      update_interval_ms <= UPDATE_INTERVAL_RESET;
      active             <= 1'b0;
      falling            <= 1'b0;
      elapsed_ms         <= '0;
      sample_ms          <= '0;
      current_volume     <= '0;
      held_pot           <= '0;
      target_volume      <= '0;
      m_axis_tvalid      <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_SWELL_TIME:      swell_time_ms      <= cfg_wdata;
          REG_UPDATE_INTERVAL: update_interval_ms <= cfg_wdata[INTERVAL_BITS-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_END) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            vol_before <= current_volume;
            state      <= ST_END;
            if (s_axis_tuser) begin
              falling       <= in_inverted;
              held_pot      <= in_pot;
              target_volume <= in_inverted ? '0 : in_pot;
              if (!in_inverted) current_volume <= '0;
              elapsed_ms    <= '0;
              sample_ms     <= '0;
              active        <= 1'b1;
            end else if (active) begin
              elapsed_ms <= elapsed_inc;
              if (need_sample) begin
                sample_ms <= elapsed_inc;
                state     <= ST_WAIT;
              end
            end
          end
        end
        ST_WAIT: begin
          if (curve_done) begin
            current_volume <= curve_y;
            state          <= ST_END;
          end
        end
        ST_END: begin
          current_volume <= cur_fin;
          active         <= act_fin;
          if (out_free) begin
            m_axis_tdata  <= OUT_W'({act_fin, cur_fin != vol_before, cur_fin});
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_on_target: assert property (@(posedge clk) disable iff (rst)
    !active |-> current_volume == target_volume)
    else $error("idle envelope is off its target volume");

  a_sample_order: assert property (@(posedge clk) disable iff (rst)
    sample_ms <= elapsed_ms)
    else $error("sample point lies beyond elapsed time");

  a_curve_when_waiting: assert property (@(posedge clk) disable iff (rst)
    curve_done |-> state == ST_WAIT)
    else $error("curve result arrived with no beat waiting for it");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END && out_free) |=> m_axis_tvalid && state == ST_IDLE)
    else $error("finished beat was not loaded into the output register");

endmodule

// ===== sv/evs_mul.sv =====
// Digit-serial multiplier that takes one byte of the multiplier per cycle.
`timescale 1ns / 1ps
module evs_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [evs_pkg::E_BITS-1:0]     a,
  input  logic [evs_pkg::ROOT_BITS-1:0]  b,
  output logic                           done,
  output logic [evs_pkg::PROD_BITS-1:0]  prod
);
  import evs_pkg::*;

  localparam int CW = $clog2(MUL_STEPS);
  localparam int SW = E_BITS + MUL_DIGIT;

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [E_BITS-1:0] a_r;
  logic [SW-1:0]     sum;

  assign sum = SW'(prod[PROD_BITS-1:ROOT_BITS]) + SW'(a_r) * SW'(prod[MUL_DIGIT-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        prod <= {{E_BITS{1'b0}}, b};
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= {sum, prod[ROOT_BITS-1:MUL_DIGIT]};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/evs_curve.sv =====
// Swell curve sequencer: serial time fraction divide, root products, pot scaling and divide by 999.
`timescale 1ns / 1ps
module evs_curve #(
  parameter int VOLUME_BITS = evs_pkg::VOLUME_BITS_DEF,
  parameter int FRAC_BITS   = evs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [evs_pkg::ELAPSED_BITS-1:0]  x,
  input  logic [evs_pkg::TIME_BITS-1:0]     t,
  input  logic                              falling,
  input  logic [VOLUME_BITS-1:0]            pot,
  output logic                              done,
  output logic [VOLUME_BITS-1:0]            y
);
  import evs_pkg::*;

  localparam int KW = $clog2(FRAC_BITS + 1);
  localparam int IW = $clog2(FRAC_BITS);
  localparam int QW = VOLUME_BITS + BASE_M1_BITS;
  localparam int JW = $clog2(VOLUME_BITS);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_DIV  = 3'd1;
  localparam logic [2:0] C_MUL  = 3'd2;
  localparam logic [2:0] C_POT  = 3'd3;
  localparam logic [2:0] C_QUO  = 3'd4;

  logic [2:0]              state;
  logic [KW-1:0]           k;
  logic [TIME_BITS-1:0]    rem;
  logic [TIME_BITS-1:0]    tr;
  logic [VOLUME_BITS-1:0]  pot_r;
  logic [E_BITS-1:0]       e;
  logic [QW-1:0]           rq;
  logic [QW-1:0]           dv;
  logic [VOLUME_BITS-1:0]  q;
  logic [JW-1:0]           j;

  logic [ROOT_BITS-1:0]    roots [FRAC_BITS];
  logic [ELAPSED_BITS-1:0] xx;
  logic                    short_path;
  logic [TIME_BITS:0]      r2;
  logic [TIME_BITS:0]      r2_sub;
  logic                    qbit;
  logic                    k_end;
  logic                    mul_go;
  logic [E_BITS-1:0]       mul_a;
  logic [ROOT_BITS-1:0]    mul_b;
  logic                    mul_done;
  logic [PROD_BITS-1:0]    prod;
  logic                    quo_ge;

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_root
    localparam logic [ROOT_BITS-1:0] ROOT = curve_root(g + 1);
    assign roots[g] = ROOT;
  end

  always_comb begin
    if (falling) begin
      xx = (x < ELAPSED_BITS'(t)) ? ELAPSED_BITS'(t) - x : '0;
    end else begin
      xx = x;
    end
  end

  assign short_path = xx >= ELAPSED_BITS'(t);
  assign r2         = {rem, 1'b0};
  assign r2_sub     = r2 - {1'b0, tr};
  assign qbit       = r2 >= {1'b0, tr};
  assign k_end      = k == KW'(FRAC_BITS);
  assign mul_go     = (state == C_DIV) && (k_end || qbit);
  assign mul_a      = k_end ? e - E_ONE : e;
  assign mul_b      = k_end ? ROOT_BITS'(pot_r) : roots[k[IW-1:0]];
  assign quo_ge     = rq >= dv;

  evs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      k     <= '0;
      j     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            pot_r <= pot;
            tr    <= t;
            if (short_path) begin
              y    <= pot;
              done <= 1'b1;
            end else begin
              rem   <= xx[TIME_BITS-1:0];
              k     <= '0;
              e     <= E_ONE;
              state <= C_DIV;
            end
          end
        end
        C_DIV: begin
          if (k_end) begin
            state <= C_POT;
          end else begin
            rem <= qbit ? r2_sub[TIME_BITS-1:0] : r2[TIME_BITS-1:0];
            k   <= k + 1'b1;
            if (qbit) state <= C_MUL;
          end
        end
        C_MUL: begin
          if (mul_done) begin
            e     <= prod[Q_ONE_BITS +: E_BITS];
            state <= C_DIV;
          end
        end
        C_POT: begin
          if (mul_done) begin
            rq    <= prod[Q_ONE_BITS +: QW];
            dv    <= QW'(BASE_M1) << (VOLUME_BITS - 1);
            j     <= JW'(VOLUME_BITS - 1);
            state <= C_QUO;
          end
        end
        C_QUO: begin
          rq <= quo_ge ? rq - dv : rq;
          dv <= dv >> 1;
          q  <= {q[VOLUME_BITS-2:0], quo_ge};
          if (j == '0) begin
            y     <= {q[VOLUME_BITS-2:0], quo_ge};
            done  <= 1'b1;
            state <= C_IDLE;
          end else begin
            j <= j - 1'b1;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
